FILE: design/cdlp_pkg.sv
// Shared constants, token types and byte codes of the CSV decimal line parser.
package cdlp_pkg;

  // Line and value geometry
  localparam int LINE_MAX   = 32;
  localparam int CNT_W      = $clog2(LINE_MAX + 1);
  localparam int VALUE_BITS = 32;
  localparam int LB_W       = 6;
  localparam int NUM_CHAN   = 4;
  localparam int FIN_N      = NUM_CHAN - 1;
  localparam int FIDX_W     = $clog2(NUM_CHAN);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Byte class as seen by the parser
  typedef enum logic [2:0] {
    CLS_WS,
    CLS_CRLF,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_COMMA,
    CLS_OTHER
  } byte_cls_t;

  // One classified byte travelling through the queue
  typedef struct packed {
    byte_cls_t  cls;
    logic [3:0] digit;
  } token_t;

endpackage

FILE: design/csv_decimal_line_parser_unit.sv
// out_valid rises as the parse engine pops a line's last byte or terminator from the queue.
// Throughput: one byte per cycle while in_stall is low; one token per cycle in the engine.
// A two-entry token queue and the result register decouple input and output stalls.
// Reset (rst_n, synchronous, active low) clears the mode to single value, empties the
// queue, drops any partial line and any pending result.
// Top level of the CSV decimal line parser.
module csv_decimal_line_parser_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic                                    cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [7:0]                              in_rx_byte,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0]  out_chan1_value,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0]  out_chan2_value,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0]  out_chan3_value,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0]  out_chan4_value,
  output logic [cdlp_pkg::LB_W-1:0]               out_line_bytes,
  output logic                                    out_saturated
);

  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;
  cdlp_pkg::token_t q_wtok;
  cdlp_pkg::token_t q_rtok;

  cdlp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wtok      (q_wtok)
  );

  cdlp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wtok     (q_wtok),
    .full     (q_full),
    .rd_valid (q_valid),
    .rtok     (q_rtok),
    .pop      (q_pop)
  );

  cdlp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_tok           (q_rtok),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chan1_value (out_chan1_value),
    .out_chan2_value (out_chan2_value),
    .out_chan3_value (out_chan3_value),
    .out_chan4_value (out_chan4_value),
    .out_line_bytes  (out_line_bytes),
    .out_saturated   (out_saturated)
  );

endmodule

FILE: design/cdlp_front.sv
// Front end: mode register, input handshake and byte classification.
module cdlp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output cdlp_pkg::token_t    q_wtok
);

  logic mode_r;

  // Channel mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the byte; a comma only splits fields in four-channel mode
  always_comb begin
    q_wtok.digit = 4'(in_rx_byte - cdlp_pkg::CH_ZERO);
    if (in_rx_byte == cdlp_pkg::CH_CR || in_rx_byte == cdlp_pkg::CH_LF) begin
      q_wtok.cls = cdlp_pkg::CLS_CRLF;
    end else if (in_rx_byte == cdlp_pkg::CH_SPACE ||
                 (in_rx_byte >= cdlp_pkg::CH_HT && in_rx_byte <= cdlp_pkg::CH_CR)) begin
      q_wtok.cls = cdlp_pkg::CLS_WS;
    end else if (in_rx_byte >= cdlp_pkg::CH_ZERO && in_rx_byte <= cdlp_pkg::CH_NINE) begin
      q_wtok.cls = cdlp_pkg::CLS_DIGIT;
    end else if (in_rx_byte == cdlp_pkg::CH_PLUS) begin
      q_wtok.cls = cdlp_pkg::CLS_PLUS;
    end else if (in_rx_byte == cdlp_pkg::CH_MINUS) begin
      q_wtok.cls = cdlp_pkg::CLS_MINUS;
    end else if (mode_r && in_rx_byte == cdlp_pkg::CH_COMMA) begin
      q_wtok.cls = cdlp_pkg::CLS_COMMA;
    end else begin
      q_wtok.cls = cdlp_pkg::CLS_OTHER;
    end
  end

endmodule

FILE: design/cdlp_queue.sv
// Two-entry token queue between the front end and the parse engine.
module cdlp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cdlp_pkg::token_t wtok,
  output logic             full,
  output logic             rd_valid,
  output cdlp_pkg::token_t rtok,
  input  logic             pop
);

  cdlp_pkg::token_t                  mem_r [cdlp_pkg::QDEPTH];
  logic [cdlp_pkg::QPTR_W-1:0]       wptr_r;
  logic [cdlp_pkg::QPTR_W-1:0]       rptr_r;
  logic [cdlp_pkg::QCNT_W-1:0]       cnt_r;
  logic                              do_pop;

  assign full     = (cnt_r == cdlp_pkg::QCNT_W'(cdlp_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rtok     = mem_r[rptr_r];
  assign do_pop   = pop && rd_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wtok;
  end

endmodule

FILE: design/cdlp_back.sv
// Parse engine: per-field atol state, line framing and the result register.
module cdlp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  cdlp_pkg::token_t                    q_tok,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0] out_chan1_value,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0] out_chan2_value,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0] out_chan3_value,
  output logic signed [cdlp_pkg::VALUE_BITS-1:0] out_chan4_value,
  output logic [cdlp_pkg::LB_W-1:0]           out_line_bytes,
  output logic                                out_saturated
);

  localparam int VB   = cdlp_pkg::VALUE_BITS;
  localparam int PW   = VB + 4;

  typedef enum logic [1:0] {PH_WS, PH_SIGN, PH_DIGITS, PH_DONE} phase_t;

  // Line and field state
  logic [cdlp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cdlp_pkg::FIDX_W-1:0] fidx_r, fidx_nxt;
  phase_t                      phase_r, phase_nxt;
  logic                        neg_r, neg_nxt;
  logic [VB-1:0]               mag_r, mag_nxt;
  logic [VB-1:0]               fin_r [cdlp_pkg::FIN_N];
  logic [VB-1:0]               fin_nxt [cdlp_pkg::FIN_N];
  logic                        ovf_r, ovf_nxt;

  // Result register
  logic                        out_valid_r;
  logic [VB-1:0]               chan_r [cdlp_pkg::NUM_CHAN];
  logic [VB-1:0]               chan_nxt [cdlp_pkg::NUM_CHAN];
  logic [cdlp_pkg::LB_W-1:0]   lb_r;

  logic                        term;
  logic                        emit;
  logic                        out_free;
  logic [VB-1:0]               cur_val;
  logic [VB-1:0]               cap;
  logic [PW-1:0]               prod;

  // Digit step: magnitude*10 + d checked against the signed clamp
  assign cap  = neg_r ? (VB'(1) << (VB - 1)) : ((VB'(1) << (VB - 1)) - 1'b1);
  assign prod = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0} + PW'(q_tok.digit);

  assign term     = (q_tok.cls == cdlp_pkg::CLS_CRLF) && (cnt_r != '0);
  assign out_free = !out_valid_r || !out_stall;

  // Next parse state for the head token
  always_comb begin
    cnt_nxt   = cnt_r;
    fidx_nxt  = fidx_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    for (int k = 0; k < cdlp_pkg::FIN_N; k++) fin_nxt[k] = fin_r[k];

    if (!term) begin
      cnt_nxt = cnt_r + 1'b1;
      if (q_tok.cls == cdlp_pkg::CLS_COMMA) begin
        // close the field unless already in the last one
        if (fidx_r != cdlp_pkg::FIDX_W'(cdlp_pkg::FIN_N)) begin
          fin_nxt[fidx_r[cdlp_pkg::FIDX_W-1:0]] = neg_r ? (VB'(0) - mag_r) : mag_r;
          fidx_nxt  = fidx_r + 1'b1;
          phase_nxt = PH_WS;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
        end
      end else begin
        unique case (phase_r)
          PH_WS: begin
            priority if (q_tok.cls == cdlp_pkg::CLS_WS ||
                         q_tok.cls == cdlp_pkg::CLS_CRLF) begin
              phase_nxt = PH_WS;
            end else if (q_tok.cls == cdlp_pkg::CLS_PLUS ||
                         q_tok.cls == cdlp_pkg::CLS_MINUS) begin
              neg_nxt   = (q_tok.cls == cdlp_pkg::CLS_MINUS);
              phase_nxt = PH_SIGN;
            end else if (q_tok.cls == cdlp_pkg::CLS_DIGIT) begin
              phase_nxt = PH_DIGITS;
              if (prod > PW'(cap)) begin
                mag_nxt = cap;
                ovf_nxt = 1'b1;
              end else begin
                mag_nxt = prod[VB-1:0];
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (q_tok.cls == cdlp_pkg::CLS_DIGIT) begin
              phase_nxt = PH_DIGITS;
              if (prod > PW'(cap)) begin
                mag_nxt = cap;
                ovf_nxt = 1'b1;
              end else begin
                mag_nxt = prod[VB-1:0];
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  // Line ends on a terminator or on the last stored byte
  assign emit  = term || (cnt_nxt == cdlp_pkg::CNT_W'(cdlp_pkg::LINE_MAX));
  assign q_pop = q_valid && (!emit || out_free);

  // Channel values as they stand after this token
  always_comb begin
    cur_val = neg_nxt ? (VB'(0) - mag_nxt) : mag_nxt;
    for (int k = 0; k < cdlp_pkg::NUM_CHAN; k++) begin
      if (k < int'(fidx_nxt)) begin
        chan_nxt[k] = (k < cdlp_pkg::FIN_N) ? fin_nxt[k % cdlp_pkg::FIN_N] : '0;
      end else if (k == int'(fidx_nxt)) begin
        chan_nxt[k] = cur_val;
      end else begin
        chan_nxt[k] = '0;
      end
    end
  end

  // State and result register; the payload loads only when a line closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      fidx_r      <= '0;
      phase_r     <= PH_WS;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < cdlp_pkg::FIN_N; k++) fin_r[k] <= '0;
    end else begin
      if (out_free) out_valid_r <= q_pop && emit;
      if (q_pop) begin
        if (emit) begin
          cnt_r   <= '0;
          fidx_r  <= '0;
          phase_r <= PH_WS;
          neg_r   <= 1'b0;
          mag_r   <= '0;
          ovf_r   <= 1'b0;
          for (int k = 0; k < cdlp_pkg::FIN_N; k++) fin_r[k] <= '0;
          for (int k = 0; k < cdlp_pkg::NUM_CHAN; k++) chan_r[k] <= chan_nxt[k];
          lb_r          <= cdlp_pkg::LB_W'(cnt_nxt);
          out_saturated <= ovf_nxt;
        end else begin
          cnt_r   <= cnt_nxt;
          fidx_r  <= fidx_nxt;
          phase_r <= phase_nxt;
          neg_r   <= neg_nxt;
          mag_r   <= mag_nxt;
          ovf_r   <= ovf_nxt;
          for (int k = 0; k < cdlp_pkg::FIN_N; k++) fin_r[k] <= fin_nxt[k];
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chan1_value = chan_r[0];
  assign out_chan2_value = chan_r[1];
  assign out_chan3_value = chan_r[2];
  assign out_chan4_value = chan_r[3];
  assign out_line_bytes  = lb_r;

`ifndef SYNTHESIS
  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < cdlp_pkg::CNT_W'(cdlp_pkg::LINE_MAX))
    else $error("line byte count reached its limit without closing");

  a_fidx_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    fidx_r != '0 |-> cnt_r != '0)
    else $error("field index advanced on an empty line");

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> lb_r != '0)
    else $error("result transaction with zero line bytes");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && emit |-> !(out_valid_r && out_stall))
    else $error("line closed while result register is held");
`endif

endmodule
